### hdl/lplmac_pkg.sv
// Package: shared types and codes for the low power listening MAC controller.
package lplmac_pkg;

  localparam int unsigned CfgWidth = 32;
  localparam int unsigned CfgIndexWidth = 2;

  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_CCA_BUSY    = 3'd1,
    KIND_CCA_CLEAR   = 3'd2,
    KIND_SENDING     = 3'd3,
    KIND_FINISHED    = 3'd4,
    KIND_SEND_FAILED = 3'd5,
    KIND_FRAME       = 3'd6,
    KIND_RESTART     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    CFG_SLEEP_TICKS  = 2'd0,
    CFG_LISTEN_TICKS = 2'd1,
    CFG_SELF_ADDR    = 2'd2,
    CFG_BCAST_ADDR   = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    SND_NONE    = 2'd0,
    SND_OKAY    = 2'd1,
    SND_DONT    = 2'd2
  } sender_cmd_e;

  typedef enum logic [1:0] {
    RADIO_NONE     = 2'd0,
    RADIO_SLEEP    = 2'd1,
    RADIO_TRANSMIT = 2'd2
  } radio_cmd_e;

  typedef enum logic [1:0] {
    NOTICE_NONE   = 2'd0,
    NOTICE_ACKED  = 2'd1,
    NOTICE_FAILED = 2'd2
  } notice_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] dest_address;
    logic [15:0] src_address;
    logic        frame_is_ack;
    logic        is_duplicate;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  mac_state;
    logic        cca_start;
    logic [1:0]  sender_cmd;
    logic [1:0]  radio_cmd;
    logic        ack_send;
    logic [15:0] ack_dest;
    logic [15:0] ack_seq;
    logic        deliver_up;
    logic [1:0]  net_notice;
    logic [15:0] notice_node;
    logic        idle_listen_event;
    logic        protocol_error;
  } out_word_t;

endpackage

### hdl/low_power_listening_mac_controller_core.sv
// Top level: duty-cycle MAC controller with event input, registered result and skid stage.
//
//   channel | direction | signals                                    | handshake
//   --------+-----------+--------------------------------------------+-------------------
//   event   | in        | in_valid_i, in_stall_o, in_word_i          | valid & !stall
//   result  | out       | out_valid_o, out_stall_i, out_word_o       | valid & !stall
//   config  | in        | cfg_we_i, cfg_index_i, cfg_data_i          | write enable
//
// One event word is accepted per cycle while in_stall_o is low; its result word is registered in out_q.
// Protocol state is updated at the accept edge, so events chain back to back.
// A skid stage holds one result while the output is stalled; in_stall_o rises
// only when both the output register and the skid stage are full.
// Reset returns the protocol to startup and loads the default configuration.
module low_power_listening_mac_controller_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lplmac_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [lplmac_pkg::CfgWidth-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lplmac_pkg::in_word_t                 in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lplmac_pkg::out_word_t                out_word_o
);
  import lplmac_pkg::*;

  typedef enum logic [2:0] {
    ST_STARTUP    = 3'd0,
    ST_POLLING    = 3'd1,
    ST_LISTENING  = 3'd2,
    ST_WAIT_SEND  = 3'd3,
    ST_SLEEPING   = 3'd4,
    ST_WAIT_SLEEP = 3'd5
  } state_e;

  logic [31:0] sleep_ticks_q;
  logic [31:0] listen_ticks_q;
  logic [15:0] self_addr_q;
  logic [15:0] bcast_addr_q;

  state_e      state_q, state_d;
  logic [31:0] sleep_left_q, sleep_left_d;
  logic [31:0] listen_left_q, listen_left_d;
  logic        sleep_paused_q, sleep_paused_d;
  logic        idle_flag_q, idle_flag_d;
  logic [15:0] ack_seq_q, ack_seq_d;

  out_word_t   res;
  out_word_t   out_q;
  out_word_t   skid_q;
  logic        out_valid_q;
  logic        skid_valid_q;
  logic        accept;
  logic        take;

  assign accept      = in_valid_i && !skid_valid_q;
  assign take        = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_ticks_q  <= 32'd1000;
      listen_ticks_q <= 32'd100;
      self_addr_q    <= 16'd0;
      bcast_addr_q   <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SLEEP_TICKS:  sleep_ticks_q  <= cfg_data_i;
        CFG_LISTEN_TICKS: listen_ticks_q <= cfg_data_i;
        CFG_SELF_ADDR:    self_addr_q    <= cfg_data_i[15:0];
        CFG_BCAST_ADDR:   bcast_addr_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // event decode: next protocol state and result word
  always_comb begin
    state_d        = state_q;
    sleep_left_d   = sleep_left_q;
    listen_left_d  = listen_left_q;
    sleep_paused_d = sleep_paused_q;
    idle_flag_d    = idle_flag_q;
    ack_seq_d      = ack_seq_q;
    res            = '0;

    unique case (kind_e'(in_word_i.kind))
      KIND_TICK: begin
        if (state_q == ST_SLEEPING) begin
          if (sleep_left_q <= 32'd1) begin
            sleep_left_d   = '0;
            res.sender_cmd = SND_DONT;
            state_d        = ST_POLLING;
            res.cca_start  = 1'b1;
          end else begin
            sleep_left_d = sleep_left_q - 32'd1;
          end
        end else if (state_q == ST_LISTENING) begin
          if (listen_left_q <= 32'd1) begin
            listen_left_d         = '0;
            res.idle_listen_event = idle_flag_q;
            state_d               = ST_WAIT_SEND;
            res.sender_cmd        = SND_OKAY;
          end else begin
            listen_left_d = listen_left_q - 32'd1;
          end
        end
      end
      KIND_CCA_BUSY: begin
        if (state_q == ST_POLLING) begin
          state_d       = ST_LISTENING;
          listen_left_d = listen_ticks_q;
          idle_flag_d   = 1'b1;
        end else begin
          res.protocol_error = 1'b1;
        end
      end
      KIND_CCA_CLEAR: begin
        if (state_q == ST_POLLING || state_q == ST_LISTENING) begin
          listen_left_d  = '0;
          state_d        = ST_WAIT_SEND;
          res.sender_cmd = SND_OKAY;
        end else begin
          res.protocol_error = 1'b1;
        end
      end
      KIND_SENDING: begin
        // pause the sleep countdown; other states ignore this event
        if (state_q == ST_SLEEPING) begin
          sleep_paused_d = 1'b1;
          state_d        = ST_WAIT_SLEEP;
        end
      end
      KIND_FINISHED: begin
        if (state_q == ST_WAIT_SLEEP && sleep_paused_q) begin
          sleep_paused_d = 1'b0;
          state_d        = ST_SLEEPING;
          res.radio_cmd  = RADIO_SLEEP;
        end else if (state_q == ST_WAIT_SEND) begin
          sleep_left_d  = sleep_ticks_q;
          state_d       = ST_SLEEPING;
          res.radio_cmd = RADIO_SLEEP;
        end else begin
          res.protocol_error = 1'b1;
        end
      end
      KIND_SEND_FAILED: begin
        res.net_notice  = NOTICE_FAILED;
        res.notice_node = in_word_i.dest_address;
      end
      KIND_FRAME: begin
        // drop frames while the radio sleeps
        if (state_q != ST_SLEEPING) begin
          if (in_word_i.dest_address == bcast_addr_q) begin
            res.deliver_up = !in_word_i.is_duplicate;
          end else if (in_word_i.dest_address != self_addr_q) begin
            res.deliver_up = !in_word_i.frame_is_ack && !in_word_i.is_duplicate;
          end else if (!in_word_i.frame_is_ack) begin
            idle_flag_d    = 1'b0;
            res.ack_send   = 1'b1;
            res.ack_dest   = in_word_i.src_address;
            res.ack_seq    = ack_seq_q;
            ack_seq_d      = ack_seq_q + 16'd1;
            res.radio_cmd  = RADIO_TRANSMIT;
            res.deliver_up = !in_word_i.is_duplicate;
          end else begin
            res.net_notice  = NOTICE_ACKED;
            res.notice_node = in_word_i.src_address;
          end
        end
      end
      KIND_RESTART: begin
        // clear run state but keep the ACK sequence
        sleep_left_d   = '0;
        listen_left_d  = '0;
        sleep_paused_d = 1'b0;
        idle_flag_d    = 1'b1;
        state_d        = ST_POLLING;
        res.cca_start  = 1'b1;
      end
      default: ;
    endcase

    res.mac_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_STARTUP;
      sleep_left_q   <= '0;
      listen_left_q  <= '0;
      sleep_paused_q <= 1'b0;
      idle_flag_q    <= 1'b1;
      ack_seq_q      <= '0;
    end else if (accept) begin
      state_q        <= state_d;
      sleep_left_q   <= sleep_left_d;
      listen_left_q  <= listen_left_d;
      sleep_paused_q <= sleep_paused_d;
      idle_flag_q    <= idle_flag_d;
      ack_seq_q      <= ack_seq_d;
    end
  end

  // output register with one-word skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

endmodule
